### src/mfs_pkg.sv
// Shared types and constants for the message fragmentation sequencer.
// No dependencies; used by every other file of the block.
package mfs_pkg;

  localparam int LEN_W  = 12;
  localparam int TYPE_W = 8;
  localparam int PLEN_W = 6;
  localparam int CNT_W  = 8;
  localparam int FAIL_W = 4;

  localparam int DIV_STEPS = LEN_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [PLEN_W-1:0] PAYLOAD_CAP    = 6'd32;
  localparam logic [LEN_W-1:0]  FRAG_COUNT_MAX = 12'd255;

  // result status codes
  localparam logic [1:0] ST_SEND   = 2'd0;
  localparam logic [1:0] ST_DONE   = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;
  localparam logic [1:0] ST_FAIL   = 2'd3;

  // frame classes
  localparam logic [1:0] CL_SINGLE = 2'd0;
  localparam logic [1:0] CL_FIRST  = 2'd1;
  localparam logic [1:0] CL_MORE   = 2'd2;
  localparam logic [1:0] CL_LAST   = 2'd3;

  typedef enum logic [1:0] {
    REG_PAYLOAD,
    REG_LIMIT,
    REG_RETRY
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [1:0]        frame_class;
    logic [TYPE_W-1:0] frame_type;
    logic [TYPE_W-1:0] reserved_value;
    logic [LEN_W-1:0]  payload_offset;
    logic [PLEN_W-1:0] payload_length;
    logic [PLEN_W-1:0] frame_bytes;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic start;
    logic result;
    logic div_step;
    logic check;
    logic calc_off;
    logic build;
    logic emit;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic kind;
    logic busy;
    logic fits;
    logic res_final;
    logic div_last;
    logic reject;
    logic out_free;
  } stat_t;

endpackage

### src/mfs_if.sv
// Valid/ready channel interfaces for request beats and descriptor beats.
// Depends on mfs_pkg for field widths.
interface mfs_in_if;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [mfs_pkg::LEN_W-1:0]  message_length;
  logic [mfs_pkg::TYPE_W-1:0] message_type;
  logic                      send_ok;

  modport source (output valid, kind, message_length, message_type, send_ok,
                  input ready);
  modport sink   (input valid, kind, message_length, message_type, send_ok,
                  output ready);
endinterface

interface mfs_out_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 status;
  logic [1:0]                 frame_class;
  logic [mfs_pkg::TYPE_W-1:0] frame_type;
  logic [mfs_pkg::TYPE_W-1:0] reserved_value;
  logic [mfs_pkg::LEN_W-1:0]  payload_offset;
  logic [mfs_pkg::PLEN_W-1:0] payload_length;
  logic [mfs_pkg::PLEN_W-1:0] frame_bytes;

  modport source (output valid, status, frame_class, frame_type, reserved_value,
                  payload_offset, payload_length, frame_bytes,
                  input ready);
  modport sink   (input valid, status, frame_class, frame_type, reserved_value,
                  payload_offset, payload_length, frame_bytes,
                  output ready);
endinterface

### src/mfs_datapath.sv
// Datapath: message state, restoring divider, offset multiply, output register.
// Depends on mfs_pkg; driven by mfs_controller commands.
module mfs_datapath #(
  parameter int HEADER_BYTES = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  mfs_pkg::cmd_t              cmd,
  output mfs_pkg::stat_t             stat,
  input  logic                       in_kind,
  input  logic [mfs_pkg::LEN_W-1:0]  in_length,
  input  logic [mfs_pkg::TYPE_W-1:0] in_type,
  input  logic                       in_ok,
  input  logic [mfs_pkg::PLEN_W-1:0] payload,
  input  logic [mfs_pkg::LEN_W-1:0]  length_limit,
  input  logic [mfs_pkg::FAIL_W-1:0] retry_limit,
  output mfs_pkg::result_t           out_res,
  output logic                       out_valid,
  input  logic                       out_ready
);

  localparam logic [mfs_pkg::PLEN_W-1:0] HDR = mfs_pkg::PLEN_W'(HEADER_BYTES);

  // staged request beat
  logic                       st_kind;
  logic [mfs_pkg::LEN_W-1:0]  st_len;
  logic [mfs_pkg::TYPE_W-1:0] st_type;
  logic                       st_ok;

  // message state
  logic                       busy;
  logic                       unfrag;
  logic [mfs_pkg::CNT_W-1:0]  frag_left;
  logic [mfs_pkg::CNT_W-1:0]  frag_sent;
  logic [mfs_pkg::FAIL_W-1:0] fails;
  logic [mfs_pkg::LEN_W-1:0]  saved_len;
  logic [mfs_pkg::TYPE_W-1:0] saved_type;

  // divider
  logic [mfs_pkg::PLEN_W-1:0]    div_rem;
  logic [mfs_pkg::LEN_W-1:0]     div_quo;
  logic [mfs_pkg::DIV_CNT_W-1:0] div_cnt;

  logic [mfs_pkg::LEN_W-1:0] off_reg;
  mfs_pkg::result_t          pend;

  logic                        fits;
  logic                        last;
  logic [mfs_pkg::FAIL_W-1:0]  fails_inc;
  logic                        abort;
  logic                        res_final;
  logic [mfs_pkg::PLEN_W+1:0]  trial;
  logic [mfs_pkg::LEN_W-1:0]   count;
  logic                        reject;
  logic [mfs_pkg::CNT_W+mfs_pkg::PLEN_W-1:0] prod;
  logic [mfs_pkg::LEN_W-1:0]   diff;
  logic [mfs_pkg::PLEN_W-1:0]  plen;
  logic                        out_free;

  assign fits      = st_len <= {{(mfs_pkg::LEN_W-mfs_pkg::PLEN_W){1'b0}}, payload};
  assign last      = frag_left == mfs_pkg::CNT_W'(1);
  assign fails_inc = fails + mfs_pkg::FAIL_W'(1);
  assign abort     = fails_inc >= retry_limit;
  assign res_final = unfrag | (st_ok & last) | (~st_ok & abort);

  // trial subtract of one restoring step; top bit set means it went negative
  assign trial = {1'b0, div_rem, div_quo[mfs_pkg::LEN_W-1]} - {2'b00, payload};
  assign count = div_quo + mfs_pkg::LEN_W'(div_rem != '0);
  assign reject = (saved_len > length_limit) || (count > mfs_pkg::FRAG_COUNT_MAX);

  assign prod = {{mfs_pkg::PLEN_W{1'b0}}, frag_sent}
              * {{mfs_pkg::CNT_W{1'b0}}, payload};

  assign diff = saved_len - off_reg;

  always_comb begin
    plen = '0;
    if (off_reg < saved_len) begin
      if (diff > {{(mfs_pkg::LEN_W-mfs_pkg::PLEN_W){1'b0}}, payload}) begin
        plen = payload;
      end else begin
        plen = diff[mfs_pkg::PLEN_W-1:0];
      end
    end
  end

  assign out_free = ~out_valid | out_ready;

  assign stat.kind      = st_kind;
  assign stat.busy      = busy;
  assign stat.fits      = fits;
  assign stat.res_final = res_final;
  assign stat.div_last  = div_cnt == mfs_pkg::DIV_CNT_W'(mfs_pkg::DIV_STEPS - 1);
  assign stat.reject    = reject;
  assign stat.out_free  = out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      unfrag     <= 1'b0;
      frag_left  <= '0;
      frag_sent  <= '0;
      fails      <= '0;
      saved_len  <= '0;
      saved_type <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.start) begin
        busy       <= fits;
        unfrag     <= fits;
        frag_left  <= '0;
        frag_sent  <= '0;
        fails      <= '0;
        saved_len  <= st_len;
        saved_type <= st_type;
      end
      if (cmd.result) begin
        if (res_final) begin
          busy      <= 1'b0;
          unfrag    <= 1'b0;
          frag_left <= '0;
          frag_sent <= '0;
          fails     <= '0;
        end else if (st_ok) begin
          fails     <= '0;
          frag_left <= frag_left - mfs_pkg::CNT_W'(1);
          frag_sent <= frag_sent + mfs_pkg::CNT_W'(1);
        end else begin
          fails <= fails_inc;
        end
      end
      if (cmd.check && !reject) begin
        busy      <= 1'b1;
        frag_left <= count[mfs_pkg::CNT_W-1:0];
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      st_kind <= in_kind;
      st_len  <= in_length;
      st_type <= in_type;
      st_ok   <= in_ok;
    end
    if (cmd.start) begin
      div_quo <= st_len;
      div_rem <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      if (trial[mfs_pkg::PLEN_W+1]) begin
        div_rem <= {div_rem[mfs_pkg::PLEN_W-2:0], div_quo[mfs_pkg::LEN_W-1]};
        div_quo <= {div_quo[mfs_pkg::LEN_W-2:0], 1'b0};
      end else begin
        div_rem <= trial[mfs_pkg::PLEN_W-1:0];
        div_quo <= {div_quo[mfs_pkg::LEN_W-2:0], 1'b1};
      end
      div_cnt <= div_cnt + mfs_pkg::DIV_CNT_W'(1);
    end
    if (cmd.calc_off) begin
      off_reg <= prod[mfs_pkg::LEN_W-1:0];
    end

    if (cmd.start && fits) begin
      pend.status         <= mfs_pkg::ST_SEND;
      pend.frame_class    <= mfs_pkg::CL_SINGLE;
      pend.frame_type     <= st_type;
      pend.reserved_value <= '0;
      pend.payload_offset <= '0;
      pend.payload_length <= st_len[mfs_pkg::PLEN_W-1:0];
      pend.frame_bytes    <= HDR + st_len[mfs_pkg::PLEN_W-1:0];
    end else if ((cmd.result && res_final) || (cmd.check && reject)) begin
      // status-only beat: every frame field is zero
      pend.frame_class    <= '0;
      pend.frame_type     <= '0;
      pend.reserved_value <= '0;
      pend.payload_offset <= '0;
      pend.payload_length <= '0;
      pend.frame_bytes    <= '0;
      if (cmd.check) begin
        pend.status <= mfs_pkg::ST_REJECT;
      end else begin
        pend.status <= st_ok ? mfs_pkg::ST_DONE : mfs_pkg::ST_FAIL;
      end
    end else if (cmd.build) begin
      pend.status         <= mfs_pkg::ST_SEND;
      pend.frame_type     <= saved_type;
      pend.payload_offset <= off_reg;
      pend.payload_length <= plen;
      pend.frame_bytes    <= HDR + plen;
      if (last) begin
        pend.frame_class    <= mfs_pkg::CL_LAST;
        pend.reserved_value <= saved_type;
      end else begin
        pend.frame_class    <= (frag_sent == '0) ? mfs_pkg::CL_FIRST : mfs_pkg::CL_MORE;
        pend.reserved_value <= frag_left;
      end
    end

    if (cmd.emit) begin
      out_res <= pend;
    end
  end

endmodule

### src/mfs_controller.sv
// Sequencing state machine for the fragmentation datapath.
// Depends on mfs_pkg command and status structs.
module mfs_controller (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  mfs_pkg::stat_t stat,
  output mfs_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_DIV,
    S_CHECK,
    S_OFFSET,
    S_BUILD,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = state == S_IDLE;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        if (!stat.kind) begin
          cmd.start  = 1'b1;
          state_next = stat.fits ? S_EMIT : S_DIV;
        end else if (!stat.busy) begin
          state_next = S_IDLE;
        end else begin
          cmd.result = 1'b1;
          state_next = stat.res_final ? S_EMIT : S_OFFSET;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_next = S_CHECK;
      end
      S_CHECK: begin
        cmd.check  = 1'b1;
        state_next = stat.reject ? S_EMIT : S_OFFSET;
      end
      S_OFFSET: begin
        cmd.calc_off = 1'b1;
        state_next   = S_BUILD;
      end
      S_BUILD: begin
        cmd.build  = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### src/message_fragmentation_sequencer_unit.sv
// From accept to descriptor valid with the output free: a final status or an unfragmented frame
// goes from decode to emit; a next fragment after a send result passes offset and build; a reject
// follows the 12-step restoring divider (one bit a cycle) and the count check; a first fragment
// follows divider, check, offset and build. Throughput: one request at a time; a waiting output
// beat does not stop the next request being taken, but the one after it waits. Reset (rst,
// synchronous, high) idles the sequencer and restores the register defaults; no clearing pass.
module message_fragmentation_sequencer_unit #(
  parameter int HEADER_BYTES    = 8,
  parameter int MAX_FRAME_BYTES = 32
) (
  input  logic        clk,
  input  logic        rst,
  mfs_in_if.sink      in_ch,
  mfs_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // default payload size is what is left of a maximum frame after the header
  localparam int PAYLOAD_DIFF = MAX_FRAME_BYTES - HEADER_BYTES;
  localparam logic [mfs_pkg::PLEN_W-1:0] PAYLOAD_RESET = PAYLOAD_DIFF[mfs_pkg::PLEN_W-1:0];

  // configuration registers
  logic [mfs_pkg::PLEN_W-1:0] cfg_payload;
  logic [mfs_pkg::LEN_W-1:0]  cfg_limit;
  logic [mfs_pkg::FAIL_W-1:0] cfg_retry;
  logic [mfs_pkg::PLEN_W-1:0] eff_payload;

  mfs_pkg::reg_idx_t reg_idx;
  logic              wr_en;

  mfs_pkg::cmd_t    cmd;
  mfs_pkg::stat_t   stat;
  mfs_pkg::result_t res;

  assign pready  = 1'b1;
  assign reg_idx = mfs_pkg::reg_idx_t'(paddr[3:2]);
  assign wr_en   = psel & penable & pwrite;

  // APB write; offsets beyond the register list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_payload <= PAYLOAD_RESET;
      cfg_limit   <= 12'd144;
      cfg_retry   <= 4'd3;
    end else if (wr_en) begin
      unique case (reg_idx)
        mfs_pkg::REG_PAYLOAD: cfg_payload <= pwdata[mfs_pkg::PLEN_W-1:0];
        mfs_pkg::REG_LIMIT:   cfg_limit   <= pwdata[mfs_pkg::LEN_W-1:0];
        mfs_pkg::REG_RETRY:   cfg_retry   <= pwdata[mfs_pkg::FAIL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      mfs_pkg::REG_PAYLOAD: prdata = {{(32-mfs_pkg::PLEN_W){1'b0}}, cfg_payload};
      mfs_pkg::REG_LIMIT:   prdata = {{(32-mfs_pkg::LEN_W){1'b0}}, cfg_limit};
      mfs_pkg::REG_RETRY:   prdata = {{(32-mfs_pkg::FAIL_W){1'b0}}, cfg_retry};
      default:              prdata = '0;
    endcase
  end

  // payload size clamped to 1..32: zero behaves as one
  always_comb begin
    priority if (cfg_payload == '0) begin
      eff_payload = mfs_pkg::PLEN_W'(1);
    end else if (cfg_payload > mfs_pkg::PAYLOAD_CAP) begin
      eff_payload = mfs_pkg::PAYLOAD_CAP;
    end else begin
      eff_payload = cfg_payload;
    end
  end

  mfs_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mfs_datapath #(
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .in_kind      (in_ch.kind),
    .in_length    (in_ch.message_length),
    .in_type      (in_ch.message_type),
    .in_ok        (in_ch.send_ok),
    .payload      (eff_payload),
    .length_limit (cfg_limit),
    .retry_limit  (cfg_retry),
    .out_res      (res),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready)
  );

  assign out_ch.status         = res.status;
  assign out_ch.frame_class    = res.frame_class;
  assign out_ch.frame_type     = res.frame_type;
  assign out_ch.reserved_value = res.reserved_value;
  assign out_ch.payload_offset = res.payload_offset;
  assign out_ch.payload_length = res.payload_length;
  assign out_ch.frame_bytes    = res.frame_bytes;

endmodule

### src/mfs_checker.sv
// Port-level checks on the descriptor beats, bound into the top level.
// Depends on mfs_pkg codes and message_fragmentation_sequencer_unit ports.
module mfs_checker #(
  parameter int HEADER_BYTES = 8
) (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] status,
  input logic [1:0] frame_class,
  input logic [7:0] frame_type,
  input logic [7:0] reserved_value,
  input logic [11:0] payload_offset,
  input logic [5:0] payload_length,
  input logic [5:0] frame_bytes
);

  localparam logic [5:0] HDR = 6'(HEADER_BYTES);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(frame_class)
      && $stable(payload_offset) && $stable(payload_length))
    else $error("descriptor beat changed while stalled");

  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != mfs_pkg::ST_SEND |-> frame_class == '0 && frame_type == '0
      && reserved_value == '0 && payload_offset == '0 && payload_length == '0
      && frame_bytes == '0)
    else $error("status beat carries frame fields");

  a_bytes: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == mfs_pkg::ST_SEND |->
      frame_bytes == HDR + payload_length && payload_length <= mfs_pkg::PAYLOAD_CAP)
    else $error("frame size does not match payload length");

  a_single_resv: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == mfs_pkg::ST_SEND && frame_class == mfs_pkg::CL_SINGLE |->
      reserved_value == '0 && payload_offset == '0)
    else $error("unfragmented frame with fragment fields");

endmodule

bind message_fragmentation_sequencer_unit mfs_checker #(
  .HEADER_BYTES (HEADER_BYTES)
) u_mfs_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .status         (out_ch.status),
  .frame_class    (out_ch.frame_class),
  .frame_type     (out_ch.frame_type),
  .reserved_value (out_ch.reserved_value),
  .payload_offset (out_ch.payload_offset),
  .payload_length (out_ch.payload_length),
  .frame_bytes    (out_ch.frame_bytes)
);
